[rtl/rbgq_pkg.sv]
// Package for the range bucketed group queues block.
// Field widths, command, status and register codes, reset values and the
// controller to datapath structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbgq_pkg;

    localparam int CMD_W     = 2;
    localparam int VAL_W     = 7;
    localparam int GRP_W     = 2;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;

    localparam int GROUPS_DEF = 4;
    localparam int DEPTH_DEF  = 16;

    localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd3;

    localparam logic [CFG_W-1:0] LIMIT0_RST = 7'd24;
    localparam logic [CFG_W-1:0] LIMIT1_RST = 7'd49;
    localparam logic [CFG_W-1:0] LIMIT2_RST = 7'd74;
    localparam logic [CFG_W-1:0] MAX_RST    = 7'd100;

    typedef struct packed {
        logic latch;
        logic exec;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic multi;
        logic rem_last;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/rbgq_ram.sv]
// Generic simple dual port RAM with registered read.
// One write port, one read port. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rbgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/rbgq_ctrl.sv]
// Controller state machine: accept, execute, emit of stored entries.
// Depends on rbgq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbgq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire rbgq_pkg::t_dp_stat i_stat,
    output rbgq_pkg::t_dp_cmd      o_cmd
);
    import rbgq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.slot_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_stat.multi ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.rem_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/rbgq_dp.sv]
// Datapath: limit registers, classifier, queue pointers and counts,
// entry RAM and output register. Depends on rbgq_pkg and rbgq_ram.
`timescale 1ns / 1ps
`default_nettype none

module rbgq_dp #(
    parameter int GROUPS = rbgq_pkg::GROUPS_DEF,
    parameter int DEPTH  = rbgq_pkg::DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire rbgq_pkg::t_dp_cmd              i_cmd,
    output rbgq_pkg::t_dp_stat                  o_stat,
    input  wire logic [rbgq_pkg::CMD_W-1:0]     i_command,
    input  wire logic [rbgq_pkg::VAL_W-1:0]     i_value,
    input  wire logic [rbgq_pkg::GRP_W-1:0]     i_group,
    input  wire logic                           i_cfg_we,
    input  wire logic [rbgq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rbgq_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [rbgq_pkg::ST_W-1:0]           o_status,
    output logic [rbgq_pkg::VAL_W-1:0]          o_item_value,
    output logic [rbgq_pkg::GRP_W-1:0]          o_item_group,
    output logic [rbgq_pkg::CNT_OUT_W-1:0]      o_group_count,
    output logic                                o_last
);
    import rbgq_pkg::*;

    localparam int GIW   = $clog2(GROUPS);
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int MEM_D = GROUPS * DEPTH;
    localparam int AW    = $clog2(MEM_D);

    function automatic logic [IW-1:0] f_wrap(input logic [IW-1:0] p);
        f_wrap = (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [GIW-1:0] g, input logic [IW-1:0] p);
        f_addr = AW'(g) * AW'(DEPTH) + AW'(p);
    endfunction

    logic [CFG_W-1:0] r_limit0;
    logic [CFG_W-1:0] r_limit1;
    logic [CFG_W-1:0] r_limit2;
    logic [CFG_W-1:0] r_max;

    logic [IW-1:0] r_head  [GROUPS];
    logic [IW-1:0] r_tail  [GROUPS];
    logic [CW-1:0] r_count [GROUPS];

    logic [CMD_W-1:0] r_cmd;
    logic [VAL_W-1:0] r_val;
    logic [GRP_W-1:0] r_grp;
    logic [GIW-1:0]   r_class;
    logic             r_reject;

    logic [GIW-1:0] r_sidx;
    logic [IW-1:0]  r_ptr;
    logic [CW-1:0]  r_rem;
    logic [CW-1:0]  r_emit_cnt;

    logic [1:0]     s_class_raw;
    logic [GIW-1:0] s_class;
    logic [GIW-1:0] s_idx;
    logic           s_valid;
    logic [CW-1:0]  s_cnt;
    logic [IW-1:0]  s_head;
    logic [IW-1:0]  s_tail;
    logic           s_empty;
    logic           s_full;
    logic           s_multi;
    logic           s_rem_last;
    logic [IW-1:0]  s_ptr_next;

    logic             s_we;
    logic [AW-1:0]    s_waddr;
    logic             s_re;
    logic [AW-1:0]    s_raddr;
    logic [VAL_W-1:0] s_rdata;

    // classifier, applied at accept
    always_comb begin
        if (i_value <= r_limit0) begin
            s_class_raw = 2'd0;
        end else if (i_value <= r_limit1) begin
            s_class_raw = 2'd1;
        end else if (i_value <= r_limit2) begin
            s_class_raw = 2'd2;
        end else begin
            s_class_raw = 2'd3;
        end
        if ({1'b0, s_class_raw} >= 3'(GROUPS)) begin
            s_class = GIW'(GROUPS - 1);
        end else begin
            s_class = GIW'(s_class_raw);
        end
    end

    always_comb begin
        if (r_cmd == CMD_ENQ) begin
            s_idx   = r_class;
            s_valid = 1'b1;
        end else begin
            s_idx   = GIW'(r_grp);
            s_valid = ({1'b0, r_grp} < 3'(GROUPS));
        end
        s_cnt      = s_valid ? r_count[s_idx] : '0;
        s_head     = r_head[s_idx];
        s_tail     = r_tail[s_idx];
        s_empty    = (s_cnt == '0);
        s_full     = (s_cnt == CW'(DEPTH));
        s_multi    = ((r_cmd == CMD_DEQ) || (r_cmd == CMD_DUMP)) && !s_empty;
        s_rem_last = (r_rem == CW'(1));
        s_ptr_next = f_wrap(r_ptr);
    end

    assign o_stat.slot_free = !o_out_valid || i_out_ready;
    assign o_stat.multi     = s_multi;
    assign o_stat.rem_last  = s_rem_last;

    assign s_we    = i_cmd.exec && (r_cmd == CMD_ENQ) && !r_reject && !s_full;
    assign s_waddr = f_addr(s_idx, s_tail);
    assign s_re    = (i_cmd.exec && s_multi) || (i_cmd.emit && !s_rem_last);
    assign s_raddr = i_cmd.exec ? f_addr(s_idx, s_head) : f_addr(r_sidx, s_ptr_next);

    rbgq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MEM_D)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (r_val),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit0 <= LIMIT0_RST;
            r_limit1 <= LIMIT1_RST;
            r_limit2 <= LIMIT2_RST;
            r_max    <= MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LIMIT0: r_limit0 <= i_cfg_data;
                REG_LIMIT1: r_limit1 <= i_cfg_data;
                REG_LIMIT2: r_limit2 <= i_cfg_data;
                REG_MAX:    r_max    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd    <= i_command;
            r_val    <= i_value;
            r_grp    <= i_group;
            r_class  <= s_class;
            r_reject <= (i_value > r_max);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < GROUPS; g++) begin
                r_head[g]  <= '0;
                r_tail[g]  <= '0;
                r_count[g] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (s_we) begin
                r_tail[s_idx]  <= f_wrap(s_tail);
                r_count[s_idx] <= s_cnt + 1'b1;
            end
            if ((r_cmd == CMD_DEQ) && s_multi) begin
                r_head[s_idx]  <= f_wrap(s_head);
                r_count[s_idx] <= s_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && s_multi) begin
            r_sidx <= s_idx;
            r_ptr  <= s_head;
            if (r_cmd == CMD_DEQ) begin
                r_rem      <= CW'(1);
                r_emit_cnt <= s_cnt - 1'b1;
            end else begin
                r_rem      <= s_cnt;
                r_emit_cnt <= s_cnt;
            end
        end else if (i_cmd.emit && !s_rem_last) begin
            r_ptr <= s_ptr_next;
            r_rem <= r_rem - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if ((i_cmd.exec && !s_multi) || i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status      <= ST_OK;
            o_item_value  <= s_rdata;
            o_item_group  <= r_grp;
            o_group_count <= CNT_OUT_W'(r_emit_cnt);
            o_last        <= s_rem_last;
        end else if (i_cmd.exec && !s_multi) begin
            o_item_value <= '0;
            o_last       <= 1'b1;
            unique case (r_cmd)
                CMD_ENQ: begin
                    if (r_reject) begin
                        o_status      <= ST_RANGE;
                        o_item_group  <= '0;
                        o_group_count <= '0;
                    end else if (s_full) begin
                        o_status      <= ST_FULL;
                        o_item_group  <= GRP_W'(r_class);
                        o_group_count <= CNT_OUT_W'(s_cnt);
                    end else begin
                        o_status      <= ST_OK;
                        o_item_group  <= GRP_W'(r_class);
                        o_group_count <= CNT_OUT_W'(s_cnt + 1'b1);
                    end
                end
                CMD_COUNT: begin
                    o_status      <= ST_OK;
                    o_item_group  <= r_grp;
                    o_group_count <= CNT_OUT_W'(s_cnt);
                end
                CMD_DEQ, CMD_DUMP: begin
                    o_status      <= ST_EMPTY;
                    o_item_group  <= r_grp;
                    o_group_count <= '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/range_bucketed_group_queues_core.sv]
// Range bucketed group queues: GROUPS circular queues of DEPTH entries fed
// by a value classifier. Top level; depends on rbgq_pkg, rbgq_ctrl, rbgq_dp.
//
// Input channel (i_in_valid / o_in_ready) carries one command beat:
// enqueue a value, dequeue a group, read a group's count or dump a group.
// Output channel (o_out_valid / i_out_ready) returns result beats; o_last
// marks the final beat of each command.
// One command is worked on at a time. Enqueue, count and any command that
// fails go from accept through the execute step to the result register;
// dequeue adds an emit step, since the entry RAM read is registered. A dump
// emits its entries one per cycle out of that RAM read port while the
// receiver takes them. A new command is accepted while the last result
// beat still waits. Stalling the receiver holds the block in its current
// step; nothing is dropped. Synchronous reset clears queue pointers,
// counts and limit registers to their defaults; the entry RAM is not
// cleared. The user must write the limit registers through i_cfg_we /
// i_cfg_idx / i_cfg_data only while the block is idle; the block itself
// does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module range_bucketed_group_queues_core #(
    parameter int GROUPS = rbgq_pkg::GROUPS_DEF,
    parameter int DEPTH  = rbgq_pkg::DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [rbgq_pkg::CMD_W-1:0]     i_command,
    input  wire logic [rbgq_pkg::VAL_W-1:0]     i_value,
    input  wire logic [rbgq_pkg::GRP_W-1:0]     i_group,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [rbgq_pkg::ST_W-1:0]           o_status,
    output logic [rbgq_pkg::VAL_W-1:0]          o_item_value,
    output logic [rbgq_pkg::GRP_W-1:0]          o_item_group,
    output logic [rbgq_pkg::CNT_OUT_W-1:0]      o_group_count,
    output logic                                o_last,
    input  wire logic                           i_cfg_we,
    input  wire logic [rbgq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rbgq_pkg::CFG_W-1:0]     i_cfg_data
);
    import rbgq_pkg::*;

    t_dp_cmd  s_cmd;
    t_dp_stat s_stat;

    rbgq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    rbgq_dp #(
        .GROUPS (GROUPS),
        .DEPTH  (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .o_stat        (s_stat),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_group       (i_group),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_item_value  (o_item_value),
        .o_item_group  (o_item_group),
        .o_group_count (o_group_count),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

[rtl/rbgq_checker.sv]
// Port level checks for range_bucketed_group_queues_core, bound to it.
// Depends on rbgq_pkg and the top level.
`timescale 1ns / 1ps
`default_nettype none

module rbgq_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [rbgq_pkg::ST_W-1:0]      o_status,
    input wire logic [rbgq_pkg::VAL_W-1:0]     o_item_value,
    input wire logic [rbgq_pkg::GRP_W-1:0]     o_item_group,
    input wire logic [rbgq_pkg::CNT_OUT_W-1:0] o_group_count,
    input wire logic                           o_last
);
    import rbgq_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("command beat accepted while previous one in progress");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_item_value) && $stable(o_group_count) && $stable(o_last))
        else $error("stalled result beat changed");

    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_last && o_item_value == '0)
        else $error("failed command not a single last beat with zero value");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_RANGE |-> o_item_group == '0 && o_group_count == '0)
        else $error("out of range result carries group or count");

endmodule

bind range_bucketed_group_queues_core rbgq_checker u_rbgq_checker (.*);

`default_nettype wire

[tb/tb.sv]
// Testbench for range_bucketed_group_queues_core: queued command stimulus, bursty
// driver, stalling monitor and a behavioural copy of the group queues for checking.
// Depends on rbgq_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
    import rbgq_pkg::*;

    localparam int GROUPS       = GROUPS_DEF;
    localparam int DEPTH        = DEPTH_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [VAL_W-1:0] value;
        logic [GRP_W-1:0] group;
    } t_cmd_beat;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [VAL_W-1:0]     item_value;
        logic [GRP_W-1:0]     item_group;
        logic [CNT_OUT_W-1:0] group_count;
        logic                 last;
    } t_result_beat;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_SPARSE} t_ready_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [CMD_W-1:0]     i_command = '0;
    logic [VAL_W-1:0]     i_value = '0;
    logic [GRP_W-1:0]     i_group = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [ST_W-1:0]      o_status;
    logic [VAL_W-1:0]     o_item_value;
    logic [GRP_W-1:0]     o_item_group;
    logic [CNT_OUT_W-1:0] o_group_count;
    logic                 o_last;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    range_bucketed_group_queues_core #(
        .GROUPS(GROUPS),
        .DEPTH (DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_value      (i_value),
        .i_group      (i_group),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_item_value (o_item_value),
        .o_item_group (o_item_group),
        .o_group_count(o_group_count),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // shadow of the block
    logic [CFG_W-1:0] lim0 = LIMIT0_RST;
    logic [CFG_W-1:0] lim1 = LIMIT1_RST;
    logic [CFG_W-1:0] lim2 = LIMIT2_RST;
    logic [CFG_W-1:0] value_ceiling = MAX_RST;
    logic [VAL_W-1:0] slot_store [GROUPS][DEPTH];
    int               head_pos [GROUPS];
    int               tail_pos [GROUPS];
    int               fill_level [GROUPS];

    t_cmd_beat    pending_cmds [$];
    t_result_beat results_due [$];
    t_cmd_beat    cmd_in_flight = '0;

    int burst_left = 0;
    int gap_left = 0;
    int beats_seen = 0;
    int hold_left = 0;
    int mode_left = 0;
    int pattern_step = 0;
    int fail_count = 0;
    int cycle_count = 0;
    t_ready_mode stall_mode = READY_ALWAYS;

    initial begin
        for (int g = 0; g < GROUPS; g++) begin
            head_pos[g] = 0;
            tail_pos[g] = 0;
            fill_level[g] = 0;
        end
    end

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic apply_command(input t_cmd_beat c);
        t_result_beat r;
        int           g;
        int           n;
        r = '0;
        r.last = 1'b1;
        case (c.command)
            CMD_ENQ: begin
                if (c.value > value_ceiling) begin
                    r.status = ST_RANGE;
                end else begin
                    if (c.value <= lim0) g = 0;
                    else if (c.value <= lim1) g = 1;
                    else if (c.value <= lim2) g = 2;
                    else g = 3;
                    if (g >= GROUPS) g = GROUPS - 1;
                    r.item_group = GRP_W'(g);
                    if (fill_level[g] >= DEPTH) begin
                        r.status = ST_FULL;
                        r.group_count = CNT_OUT_W'(DEPTH);
                    end else begin
                        slot_store[g][tail_pos[g]] = c.value;
                        tail_pos[g] = (tail_pos[g] + 1) % DEPTH;
                        fill_level[g]++;
                        r.status = ST_OK;
                        r.group_count = CNT_OUT_W'(fill_level[g]);
                    end
                end
                results_due.push_back(r);
            end
            CMD_COUNT: begin
                r.status = ST_OK;
                r.item_group = c.group;
                r.group_count = (c.group < GROUPS) ? CNT_OUT_W'(fill_level[c.group]) : '0;
                results_due.push_back(r);
            end
            default: begin
                g = int'(c.group);
                r.item_group = c.group;
                if (g >= GROUPS || fill_level[g] == 0) begin
                    r.status = ST_EMPTY;
                    results_due.push_back(r);
                end else if (c.command == CMD_DEQ) begin
                    r.status = ST_OK;
                    r.item_value = slot_store[g][head_pos[g]];
                    head_pos[g] = (head_pos[g] + 1) % DEPTH;
                    fill_level[g]--;
                    r.group_count = CNT_OUT_W'(fill_level[g]);
                    results_due.push_back(r);
                end else begin
                    n = (fill_level[g] > DEPTH) ? DEPTH : fill_level[g];
                    for (int i = 0; i < n; i++) begin
                        r.status = ST_OK;
                        r.item_value = slot_store[g][(head_pos[g] + i) % DEPTH];
                        r.group_count = CNT_OUT_W'(fill_level[g]);
                        r.last = (i + 1 == n);
                        results_due.push_back(r);
                    end
                end
            end
        endcase
    endtask

    // command driver: bursts of beats with random gaps
    always @(posedge i_clk) begin : cmd_driver
        logic offer;
        offer = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                apply_command(cmd_in_flight);
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_cmds.size() > 0) begin
                    cmd_in_flight = pending_cmds.pop_front();
                    offer = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
        i_in_valid <= offer;
        i_command  <= cmd_in_flight.command;
        i_value    <= cmd_in_flight.value;
        i_group    <= cmd_in_flight.group;
    end

    // result monitor and receiver stall pattern
    always @(posedge i_clk) begin : beat_checker
        t_result_beat want;
        logic         rdy;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_seen++;
            if (results_due.size() == 0) begin
                $error("unexpected result beat: status %0d value %0d group %0d",
                       o_status, o_item_value, o_item_group);
                fail_count++;
            end else begin
                want = results_due.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_item_value !== want.item_value) begin
                    $error("item_value: expected %0d, got %0d", want.item_value, o_item_value);
                    fail_count++;
                end
                if (o_item_group !== want.item_group) begin
                    $error("item_group: expected %0d, got %0d", want.item_group, o_item_group);
                    fail_count++;
                end
                if (o_group_count !== want.group_count) begin
                    $error("group_count: expected %0d, got %0d",
                           want.group_count, o_group_count);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    fail_count++;
                end
            end
            if (beats_seen == 100 || beats_seen == 600) hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            stall_mode = t_ready_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
        end else begin
            mode_left--;
        end
        pattern_step++;
        case (stall_mode)
            READY_ALWAYS:   rdy = 1'b1;
            READY_COIN:     rdy = 1'($urandom_range(0, 1));
            READY_PERIODIC: rdy = (pattern_step % 3) != 0;
            default:        rdy = ($urandom_range(0, 3) == 0);
        endcase
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end
        i_out_ready <= rdy;
    end

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                            input logic [GRP_W-1:0] grp);
        t_cmd_beat c;
        c.command = cmd;
        c.value = val;
        c.group = grp;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (!(pending_cmds.size() == 0 && !i_in_valid && results_due.size() == 0));
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_LIMIT0: lim0 = data;
            REG_LIMIT1: lim1 = data;
            REG_LIMIT2: lim2 = data;
            default:    value_ceiling = data;
        endcase
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] l0, input logic [CFG_W-1:0] l1,
                              input logic [CFG_W-1:0] l2, input logic [CFG_W-1:0] mx);
        write_reg(REG_LIMIT0, l0);
        write_reg(REG_LIMIT1, l1);
        write_reg(REG_LIMIT2, l2);
        write_reg(REG_MAX, mx);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int enq_pct;
        int pick;
        int a;
        int b;
        int c;
        int d;
        logic [VAL_W-1:0] v;
        @(posedge i_rst_n);
        @(negedge i_clk);

        // default limits: boundaries, rejects, empty groups
        push_cmd(CMD_COUNT, 7'd0, 2'd0);
        push_cmd(CMD_COUNT, 7'd127, 2'd3);
        push_cmd(CMD_DEQ, 7'd0, 2'd1);
        push_cmd(CMD_DUMP, 7'd0, 2'd2);
        push_cmd(CMD_ENQ, 7'd0, 2'd3);
        push_cmd(CMD_ENQ, 7'd24, 2'd0);
        push_cmd(CMD_ENQ, 7'd25, 2'd0);
        push_cmd(CMD_ENQ, 7'd49, 2'd0);
        push_cmd(CMD_ENQ, 7'd50, 2'd0);
        push_cmd(CMD_ENQ, 7'd74, 2'd0);
        push_cmd(CMD_ENQ, 7'd75, 2'd0);
        push_cmd(CMD_ENQ, 7'd100, 2'd0);
        push_cmd(CMD_ENQ, 7'd101, 2'd0);
        push_cmd(CMD_ENQ, 7'd127, 2'd3);
        push_cmd(CMD_DUMP, 7'd0, 2'd1);
        push_cmd(CMD_DEQ, 7'd0, 2'd0);
        push_cmd(CMD_COUNT, 7'd0, 2'd0);
        push_cmd(CMD_DEQ, 7'd0, 2'd3);
        push_cmd(CMD_DUMP, 7'd0, 2'd3);
        push_cmd(CMD_COUNT, 7'd0, 2'd2);
        wait_idle();

        // everything to group 0: fill to full, overflow, full dump
        set_limits(7'd127, 7'd127, 7'd127, 7'd127);
        @(negedge i_clk);
        for (int i = 0; i < 17; i++) push_cmd(CMD_ENQ, VAL_W'($urandom_range(0, 127)), 2'd0);
        push_cmd(CMD_DUMP, 7'd0, 2'd0);
        push_cmd(CMD_DEQ, 7'd0, 2'd0);
        push_cmd(CMD_ENQ, 7'd127, 2'd1);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_limits(7'd0, 7'd0, 7'd0, 7'd0);
                1: set_limits(7'd0, 7'd0, 7'd0, 7'd127);
                2: set_limits(7'd100, 7'd20, 7'd60, 7'd127);
                7: set_limits(LIMIT0_RST, LIMIT1_RST, LIMIT2_RST, MAX_RST);
                default: begin
                    if ($urandom_range(0, 1)) begin
                        a = $urandom_range(0, 100);
                        b = $urandom_range(a, 127);
                        c = $urandom_range(b, 127);
                        d = $urandom_range(c, 127);
                    end else begin
                        a = $urandom_range(0, 127);
                        b = $urandom_range(0, 127);
                        c = $urandom_range(0, 127);
                        d = $urandom_range(0, 127);
                    end
                    set_limits(CFG_W'(a), CFG_W'(b), CFG_W'(c), CFG_W'(d));
                end
            endcase
            @(negedge i_clk);
            enq_pct = $urandom_range(30, 70);
            for (int i = 0; i < 55; i++) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 9) < 7) v = VAL_W'($urandom_range(0, value_ceiling));
                else v = VAL_W'($urandom_range(0, 127));
                if (pick < enq_pct) begin
                    push_cmd(CMD_ENQ, v, GRP_W'($urandom_range(0, 3)));
                end else begin
                    pick = $urandom_range(0, 19);
                    if (pick < 9) push_cmd(CMD_DEQ, v, GRP_W'($urandom_range(0, 3)));
                    else if (pick < 15) push_cmd(CMD_DUMP, v, GRP_W'($urandom_range(0, 3)));
                    else push_cmd(CMD_COUNT, v, GRP_W'($urandom_range(0, 3)));
                end
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && results_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
